// ===== rtl/hkst_pkg.sv =====
// Shared constants and codes for the hashed key set table.
package hkst_pkg;

  localparam int KEY_W         = 64;
  localparam int BUCKETS_DEF   = 1321;
  localparam int WAYS_DEF      = 4;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_SKIPPED = 2'd3
  } status_e;

endpackage

// ===== rtl/hkst_mod_unit.sv =====
// Pipelined remainder of a 64-bit key by the bucket count.
module hkst_mod_unit #(
  parameter int BUCKETS = hkst_pkg::BUCKETS_DEF,
  parameter int ROW_W   = $clog2(BUCKETS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hkst_pkg::KEY_W-1:0] key_i,
  output logic                       done_o,
  output logic [ROW_W-1:0]           rem_o
);
  import hkst_pkg::*;

  localparam int CHUNK_W = 16;
  localparam int S_W     = CHUNK_W + ROW_W + 2;
  localparam int P_W     = 2 * S_W;
  localparam int RW1     = ROW_W + 1;

  localparam logic [S_W-1:0] RES1      = S_W'((64'd1 << CHUNK_W) % 64'(BUCKETS));
  localparam logic [S_W-1:0] RES2      = S_W'((64'd1 << (2 * CHUNK_W)) % 64'(BUCKETS));
  localparam logic [S_W-1:0] RES3      = S_W'((64'd1 << (3 * CHUNK_W)) % 64'(BUCKETS));
  localparam logic [S_W-1:0] RECIP     = S_W'((64'd1 << S_W) / 64'(BUCKETS));
  localparam logic [S_W-1:0] BUCKETS_S = S_W'(BUCKETS);
  localparam logic [ROW_W:0] BUCKETS_R = RW1'(BUCKETS);

  logic             v1_q;
  logic             v2_q;
  logic             done_q;
  logic [S_W-1:0]   sum_d;
  logic [S_W-1:0]   sum_q;
  logic [S_W-1:0]   sum2_q;
  logic [S_W-1:0]   quo_q;
  logic [P_W-1:0]   prod;
  logic [S_W-1:0]   diff;
  logic [ROW_W:0]   rem_w;
  logic [ROW_W:0]   rem_c;
  logic [ROW_W-1:0] rem_d;
  logic [ROW_W-1:0] rem_q;

  // The key is folded as four 16-bit chunks, each weighted by the residue of
  // its place value, which keeps the sum congruent to the key.
  assign sum_d = S_W'(key_i[CHUNK_W-1:0])
               + S_W'(key_i[2*CHUNK_W-1:CHUNK_W]) * RES1
               + S_W'(key_i[3*CHUNK_W-1:2*CHUNK_W]) * RES2
               + S_W'(key_i[KEY_W-1:3*CHUNK_W]) * RES3;

  // The reciprocal quotient is at most one below the true one, so the
  // difference lies under twice the bucket count and one correction suffices.
  assign prod  = P_W'(sum_q) * P_W'(RECIP);
  assign diff  = sum2_q - quo_q * BUCKETS_S;
  assign rem_w = diff[ROW_W:0];
  assign rem_c = rem_w - BUCKETS_R;
  assign rem_d = (rem_w >= BUCKETS_R) ? rem_c[ROW_W-1:0] : rem_w[ROW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
    end
    if (v1_q) begin
      quo_q  <= prod[P_W-1:S_W];
      sum2_q <= sum_q;
    end
    if (v2_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/hkst_row_mem.sv =====
// Synchronous bucket row memory with one write and one registered read port.
module hkst_row_mem #(
  parameter int DEPTH  = hkst_pkg::BUCKETS_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = hkst_pkg::WAYS_DEF * (hkst_pkg::KEY_W + 1)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hashed_key_set_table_unit.sv =====
// Top level of the hashed key set table: request control and row update logic.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start high, busy low      action_i, key_i, batch_end_i
//   result    out        status_valid_o, 1 cycle   status_o
//
// A request runs from acceptance to its result through the remainder unit
// that maps the key to its bucket (chunk fold, reciprocal multiply, subtract
// and correct), then the row is read, compared and written back. One request
// is in flight at a time; busy is high until the request's row update is
// done, and the result strobe follows in the next cycle, so a new request
// can be accepted as soon as the result strobe appears.
// After reset a clearing pass writes every row empty, BUCKETS rows (1321 by
// default), with busy high. The receiver cannot stall results.
module hashed_key_set_table_unit #(
  parameter int BUCKETS = hkst_pkg::BUCKETS_DEF,
  parameter int WAYS    = hkst_pkg::WAYS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action_i,
  input  logic [hkst_pkg::KEY_W-1:0] key_i,
  input  logic                       batch_end_i,
  output logic                       status_valid_o,
  output logic [1:0]                 status_o
);
  import hkst_pkg::*;

  localparam int ROW_W  = $clog2(BUCKETS);
  localparam int DATA_W = WAYS * (KEY_W + 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BUCKETS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_EXEC
  } state_e;

  state_e           state_q;
  logic [ROW_W-1:0] clr_q;
  logic             bf_q;
  logic             sv_q;
  status_e          status_q;

  // Request payload, held for the whole request.
  action_e          act_q;
  logic [KEY_W-1:0] key_q;
  logic             last_q;
  logic [ROW_W-1:0] row_q;

  logic             accept;
  logic             mod_done;
  logic [ROW_W-1:0] mod_rem;

  logic [DATA_W-1:0]           rd_data;
  logic [WAYS-1:0]             rd_valid;
  logic [WAYS-1:0][KEY_W-1:0]  rd_keys;
  logic [WAYS-1:0]             hit;
  logic [WAYS-1:0]             free_oh;
  logic                        any_hit;
  logic                        row_full;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0][KEY_W-1:0]  new_keys;
  logic                        exec_wr;
  status_e                     status_d;
  logic                        bf_d;

  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  hkst_mod_unit #(
    .BUCKETS (BUCKETS),
    .ROW_W   (ROW_W)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // The read is issued the cycle the bucket index is ready, so the row data is
  // registered and waiting when the state machine enters its update cycle.
  // The write-back lands long before the next request can read any row, so
  // the read-modify-write never overlaps another access.
  assign mem_re    = (state_q == S_MOD) && mod_done;
  assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_EXEC) && exec_wr);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : row_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : {new_valid, new_keys};

  hkst_row_mem #(
    .DEPTH   (BUCKETS),
    .ADDR_W  (ROW_W),
    .DATA_W  (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mod_rem),
    .rdata_o (rd_data)
  );

  assign {rd_valid, rd_keys} = rd_data;

  // All ways are compared at once. The lowest free way is the lowest clear
  // valid bit, isolated by the usual add-one trick.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = rd_valid[w] && (rd_keys[w] == key_q);
    end
  end

  assign any_hit  = |hit;
  assign row_full = &rd_valid;
  assign free_oh  = ~rd_valid & (rd_valid + WAYS'(1));

  // Row update and status. A skipped insert during a failed batch leaves the
  // row alone; the request that carries batch_end closes the failed batch.
  // Any request other than an insert starts a new batch.
  always_comb begin
    new_valid = rd_valid;
    new_keys  = rd_keys;
    exec_wr   = 1'b0;
    status_d  = ST_DONE;
    bf_d      = 1'b0;
    unique case (act_q)
      ACT_INSERT: begin
        if (bf_q) begin
          status_d = ST_SKIPPED;
          bf_d     = !last_q;
        end else if (any_hit) begin
          status_d = ST_DONE;
        end else if (row_full) begin
          status_d = ST_FULL;
          bf_d     = !last_q;
        end else begin
          for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
              new_keys[w] = key_q;
            end
          end
          new_valid = rd_valid | free_oh;
          exec_wr   = 1'b1;
          status_d  = ST_DONE;
        end
      end
      ACT_DELETE: begin
        new_valid = rd_valid & ~hit;
        exec_wr   = any_hit;
        status_d  = ST_DONE;
      end
      ACT_FIND: begin
        status_d = any_hit ? ST_DONE : ST_ABSENT;
      end
      default: begin
        status_d = ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      bf_q     <= 1'b0;
      sv_q     <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      sv_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ROW_W'(1);
          if (clr_q == LAST_ROW) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          bf_q     <= bf_d;
          status_q <= status_d;
          sv_q     <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(action_i);
      key_q  <= key_i;
      last_q <= batch_end_i;
    end
    if ((state_q == S_MOD) && mod_done) begin
      row_q <= mod_rem;
    end
  end

  assign status_valid_o = sv_q;
  assign status_o       = status_q;

endmodule

// ===== rtl/hkst_checker.sv =====
// Port-level checks for the hashed key set table, bound to the top level.
module hkst_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       status_valid_o
);

  // An accepted request keeps the unit busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy afterwards");

  // A result only appears just after the unit was busy with a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o |-> $past(busy))
    else $error("result strobe without a request in work");

  // Each request yields a single result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o |=> !status_valid_o)
    else $error("result strobe held for more than one cycle");

  // The result strobe never coincides with work on a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_valid_o |-> !busy)
    else $error("result strobe while the unit is busy");

endmodule

bind hashed_key_set_table_unit hkst_checker u_hkst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .status_valid_o (status_valid_o)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the hashed key set table: directed and random requests.
`timescale 1ns / 1ps

// The driver feeds requests from a queue that the stimulus block fills up front.
// Every accepted request runs through a local copy of the table, which yields the
// status the block must return. The monitor compares each result strobe against
// the oldest outstanding expectation. The block keeps one request in flight and
// cannot stall its results, so only the request side is paced.
module tb_top;
  import hkst_pkg::*;

  localparam int BUCKETS        = BUCKETS_DEF;
  localparam int WAYS           = WAYS_DEF;
  localparam int ENTRIES        = BUCKETS * WAYS;
  localparam int PHASE_ITEMS    = 300;
  localparam int TAIL_CYCLES    = 40;
  // Quiet cycles allowed before the run is declared hung. The longest legal gap
  // is the reset hold and the clearing pass after it plus the run of a single request to its result.
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    action_e     act;
    logic [63:0] key;
    logic        last;
    int          idle_pct;
    bit          drain;
  } request_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic [1:0]  action_i    = 2'b00;
  logic [63:0] key_i       = '0;
  logic        batch_end_i = 1'b0;
  logic        status_valid_o;
  logic [1:0]  status_o;

  hashed_key_set_table_unit #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .key_i         (key_i),
    .batch_end_i   (batch_end_i),
    .status_valid_o(status_valid_o),
    .status_o      (status_o)
  );

  // Pending requests, the expected statuses of accepted ones, and bookkeeping.
  request_t    request_q[$];
  status_e     status_exp_q[$];
  logic [63:0] key_pool[$];
  int          issued_cnt = 0;
  int          done_cnt   = 0;
  int          fail_cnt   = 0;
  int          quiet_cnt  = 0;
  int          status_seen[4];
  int          cur_idle   = 0;

  // Local image of the table: stored keys, their valid bits and the sticky flag
  // that makes the rest of a failed insert batch skip.
  logic [63:0] tbl_key[ENTRIES];
  bit          tbl_valid[ENTRIES];
  bit          batch_failed;

  // Applies one request to the local table and returns the status it must produce.
  function automatic status_e apply_request(action_e act, logic [63:0] k, logic last);
    int      base;
    int      hit_way;
    int      free_way;
    int      w;
    status_e st;
    base     = int'(k % 64'(BUCKETS)) * WAYS;
    hit_way  = -1;
    free_way = -1;
    for (w = WAYS - 1; w >= 0; w--) begin
      if (tbl_valid[base + w] && tbl_key[base + w] == k) hit_way = w;
      if (!tbl_valid[base + w]) free_way = w;
    end
    st = ST_DONE;
    if (act == ACT_INSERT) begin
      if (batch_failed) begin
        // The batch already failed: every further insert is skipped up to its end.
        st = ST_SKIPPED;
        if (last) batch_failed = 1'b0;
      end else if (hit_way >= 0) begin
        st = ST_DONE;
      end else if (free_way < 0) begin
        st           = ST_FULL;
        batch_failed = !last;
      end else begin
        tbl_key[base + free_way]   = k;
        tbl_valid[base + free_way] = 1'b1;
      end
    end else begin
      // Any other action starts a new batch.
      batch_failed = 1'b0;
      if (act == ACT_DELETE) begin
        for (w = 0; w < WAYS; w++) begin
          if (tbl_valid[base + w] && tbl_key[base + w] == k) tbl_valid[base + w] = 1'b0;
        end
      end else if (act == ACT_FIND) begin
        st = (hit_way >= 0) ? ST_DONE : ST_ABSENT;
      end else begin
        st = ST_ABSENT;
      end
    end
    return st;
  endfunction

  // Builds a key that lands in the given row. Small multipliers recur often, which
  // produces duplicate inserts and deletes that hit.
  function automatic logic [63:0] key_for_row(int row);
    logic [63:0] mult;
    if ($urandom_range(0, 1) == 0) mult = 64'($urandom_range(0, 7));
    else mult = {$urandom(), $urandom()} >> 11;
    return 64'(row) + mult * 64'(BUCKETS);
  endfunction

  function automatic logic [63:0] pool_or_fresh(int row);
    if (key_pool.size() > 0 && $urandom_range(0, 99) < 70)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return key_for_row(row);
  endfunction

  task automatic add_request(action_e a, logic [63:0] k, logic last, bit drain = 1'b0);
    request_t r;
    r.act      = a;
    r.key      = k;
    r.last     = last;
    r.idle_pct = cur_idle;
    r.drain    = drain;
    request_q.push_back(r);
    if (a == ACT_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Driver. A request stays on the ports until it is accepted; a new one is only
  // presented when the idle roll allows it and, for a request marked to drain,
  // once every earlier result has come back.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic     accepted;
    logic     go;
    request_t head;
    if (!rst_ni) begin
      start       <= 1'b0;
      action_i    <= ACT_INSERT;
      key_i       <= '0;
      batch_end_i <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        head = request_q.pop_front();
        status_exp_q.push_back(apply_request(head.act, head.key, head.last));
        issued_cnt++;
      end
      if (start && !accepted) begin
        // Still waiting for the block; hold the request as it is.
        go = 1'b1;
      end else begin
        go = 1'b0;
        if (request_q.size() > 0) begin
          head = request_q[0];
          go   = ($urandom_range(0, 99) >= head.idle_pct) &&
                 (!head.drain || issued_cnt == done_cnt);
          if (go) begin
            action_i    <= head.act;
            key_i       <= head.key;
            batch_end_i <= head.last;
          end
        end
      end
      start <= go;
    end
  end

  // Monitor. Every strobe must match the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_proc
    status_e exp_st;
    if (rst_ni && status_valid_o) begin
      if (status_exp_q.size() == 0) begin
        $error("status: result with no request outstanding, actual %0d", status_o);
        fail_cnt++;
      end else begin
        exp_st = status_exp_q.pop_front();
        if (status_o !== exp_st) begin
          $error("status mismatch: expected %0d, actual %0d", exp_st, status_o);
          fail_cnt++;
        end
        status_seen[exp_st]++;
        done_cnt <= done_cnt + 1;
      end
    end
  end

  // Watchdog: ends the run if neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || status_valid_o) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stim_proc
    logic [63:0] s;
    logic [63:0] r5;
    int          hot_rows[8];
    int          phase;
    int          len;
    int          i;
    int          pick;
    int          base_cnt;
    int          idle_by_phase[4];

    s  = 64'(BUCKETS);
    r5 = 64'd5;
    idle_by_phase = '{0, 60, 0, 11};

    // Directed part: empty table, duplicates, both extremes of the key, a full
    // row inside a batch with the skipped inserts after it, a full row on the
    // last key of a batch, a batch broken by a find, deletes of absent and
    // present keys, reuse of a freed way, and the unused action.
    cur_idle = 0;
    add_request(ACT_FIND,   64'd0, 1'b1);
    add_request(ACT_INSERT, 64'd0, 1'b1);
    add_request(ACT_INSERT, 64'd0, 1'b1);
    add_request(ACT_FIND,   64'd0, 1'b1);
    add_request(ACT_INSERT, '1, 1'b1);
    add_request(ACT_FIND,   '1, 1'b1);
    add_request(ACT_INSERT, 64'h8000_0000_0000_0000, 1'b1);
    add_request(ACT_DELETE, 64'h8000_0000_0000_0000, 1'b1);
    add_request(ACT_FIND,   64'h8000_0000_0000_0000, 1'b1);
    for (i = 0; i < 4; i++) add_request(ACT_INSERT, r5 + s * 64'(i), 1'b0);
    add_request(ACT_INSERT, r5 + s * 64'd4, 1'b0);
    add_request(ACT_INSERT, r5 + s * 64'd5, 1'b0);
    add_request(ACT_INSERT, r5 + s * 64'd6, 1'b1);
    add_request(ACT_INSERT, r5 + s * 64'd4, 1'b1);
    add_request(ACT_INSERT, 64'd7, 1'b1);
    add_request(ACT_INSERT, r5 + s * 64'd5, 1'b0);
    add_request(ACT_FIND,   r5 + s * 64'd2, 1'b1);
    add_request(ACT_INSERT, 64'd9, 1'b1);
    add_request(ACT_DELETE, 64'd12345, 1'b1);
    add_request(ACT_DELETE, r5 + s, 1'b1);
    add_request(ACT_INSERT, r5 + s * 64'd4, 1'b1);
    add_request(ACT_UNUSED, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
    add_request(ACT_FIND,   r5 + s * 64'd4, 1'b1);

    // Random part in pacing phases. Most traffic is well-formed batches aimed at
    // a few hot rows, so rows fill up and batches fail; the rest is noise.
    for (phase = 0; phase < 4; phase++) begin
      cur_idle    = idle_by_phase[phase];
      hot_rows[0] = 0;
      hot_rows[1] = BUCKETS - 1;
      for (i = 2; i < 8; i++) hot_rows[i] = $urandom_range(0, BUCKETS - 1);
      base_cnt = request_q.size();
      // Each phase after the first opens by letting every outstanding result come back first.
      if (phase > 0) add_request(ACT_FIND, key_for_row(hot_rows[0]), 1'b1, 1'b1);
      while (request_q.size() - base_cnt < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          len = $urandom_range(1, 6);
          for (i = 0; i < len; i++)
            add_request(ACT_INSERT, key_for_row(hot_rows[$urandom_range(0, 7)]),
                        (i == len - 1) || ($urandom_range(0, 99) < 10));
        end else if (pick < 60) begin
          len = $urandom_range(1, 3);
          for (i = 0; i < len; i++)
            add_request(ACT_DELETE, pool_or_fresh(hot_rows[$urandom_range(0, 7)]),
                        (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
        end else if (pick < 85) begin
          add_request(ACT_FIND, pool_or_fresh(hot_rows[$urandom_range(0, 7)]),
                      1'($urandom_range(0, 1)), $urandom_range(0, 99) == 0);
        end else if (pick < 92) begin
          add_request(ACT_UNUSED, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)));
        end else begin
          add_request(action_e'($urandom_range(0, 3)), {$urandom(), $urandom()},
                      1'($urandom_range(0, 1)));
        end
      end
    end

    // Reset once, then let the driver empty the queue.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (request_q.size() != 0 || start || done_cnt != issued_cnt) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (status_exp_q.size() != 0) begin
      $error("status: %0d expected results never arrived", status_exp_q.size());
      fail_cnt++;
    end
    $display("Ran %0d requests (directed cases, batches on hot rows, noise) in 4 pacing phases.",
             issued_cnt);
    $display("Statuses seen: %0d done, %0d absent, %0d full, %0d skipped.",
             status_seen[ST_DONE], status_seen[ST_ABSENT], status_seen[ST_FULL],
             status_seen[ST_SKIPPED]);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hkst_pkg.sv
rtl/hkst_mod_unit.sv
rtl/hkst_row_mem.sv
rtl/hashed_key_set_table_unit.sv
rtl/hkst_checker.sv
sim/tb_top.sv
